// ----- src/ctg_pkg.sv -----
package ctg_pkg;

   // Fixed field widths
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int RSP_DATA_W = 80;
   localparam int REQ_DATA_W = 8;

   // Default parameter values
   localparam int MAX_SAMPLES_DEF = 65536;
   localparam int FRAC_BITS_DEF   = 16;

   // Saturation limit of all wide intermediates
   localparam logic signed [63:0] WIDE_LIM = 64'sh4000_0000_0000_0000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_START_POS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_END_POS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_START_VEL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_END_VEL   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_START_TIM = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_END_TIM   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD    = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_DIV_POST,
      ST_TAU,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_MUL_FIN,
      ST_ACC,
      ST_NEXT
   } ctg_state_type;

   // Divider passes of a restart, in order
   typedef enum logic [2:0] {
      DIV_QUAD_X,
      DIV_QUAD,
      DIV_CUBIC_X,
      DIV_CUBIC_Y,
      DIV_CUBIC,
      DIV_COUNT
   } ctg_div_type;

   // Horner steps of one sample
   typedef enum logic [2:0] {
      H_POS_QUAD,
      H_POS_LIN,
      H_POS_CONST,
      H_VEL_QUAD,
      H_VEL_LIN
   } ctg_horner_type;

endpackage

// ----- src/cubic_trajectory_generator.sv -----
// Cubic trajectory generator: samples position and velocity of a cubic path.
// Configuration: csr_we / csr_index / csr_wdata write registers 0..6
// (start/end position, start/end velocity, start/end time, sample period),
// each taken at the clock edge where csr_we is high; write only while idle.
// Input channel req_*: one transfer per tick; req_tdata[0] = restart.
// Restart solves the coefficients through one shared bit-serial divider
// (six passes, each through DIV_LOAD, DIV_RUN and DIV_POST) and then emits
// sample zero; an empty span answers from ST_START without dividing.
// A plain tick forms the sample time in ST_TAU, then runs five Horner steps
// on one 32x32 multiplier shared with ST_TAU, each step through MUL_LO,
// MUL_HI, MUL_FIN, ACC and NEXT. The next tick is taken in the cycle after
// the result transfer.
// A plain tick while no path is running gives nothing.
// Output channel rsp_*: one transfer per sample; rsp_tlast marks the final
// sample, rsp_tuser marks an empty span (end time not after start time).
// One item is in work at a time; req_tready is low while busy or while a
// result waits. A stalled receiver holds the result register and the block.
// Reset (synchronous, active high) clears coefficients and counters, loads
// the register defaults and returns to idle.
module cubic_trajectory_generator #(
   parameter int MAX_SAMPLES = ctg_pkg::MAX_SAMPLES_DEF,
   parameter int FRAC_BITS   = ctg_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [ctg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ctg_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ctg_pkg::REQ_DATA_W-1:0]   req_tdata,   // [0] restart
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ctg_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // position, velocity, sample_number
   output logic                             rsp_tlast,   // last_sample
   output logic                             rsp_tuser    // empty_span
);

   localparam int COEFF_W = 32 + FRAC_BITS;
   localparam int IDX_W   = $clog2(MAX_SAMPLES + 1);
   localparam int DNUM_W  = 63 + FRAC_BITS;
   localparam int CNT_W   = $clog2(DNUM_W);
   localparam logic signed [63:0] COEFF_LIM = (64'sd1 <<< (COEFF_W - 1)) - 64'sd1;

   // Clamp a sum to +-lim
   function automatic logic signed [63:0] sat_to(input logic signed [64:0] x,
                                                 input logic signed [63:0] lim);
      logic signed [64:0] l;
      l = 65'(lim);
      if (x > l) sat_to = lim;
      else if (x < -l) sat_to = -lim;
      else sat_to = x[63:0];
   endfunction

   // Drop fraction bits toward zero, saturate to 32 bits
   function automatic logic [31:0] to_out(input logic signed [63:0] a);
      logic [63:0]        m;
      logic signed [63:0] v;
      m = (a < 0) ? 64'(-a) : 64'(a);
      m = m >> FRAC_BITS;
      v = (a < 0) ? -$signed(m) : $signed(m);
      if (v > 64'sd2147483647) to_out = 32'h7FFF_FFFF;
      else if (v < -64'sd2147483648) to_out = 32'h8000_0000;
      else to_out = v[31:0];
   endfunction

   // Configuration registers
   logic signed [31:0] sp_ff, ep_ff, sv_ff, ev_ff;
   logic [31:0]        st_ff, et_ff, per_ff;

   // Control
   ctg_pkg::ctg_state_type  state_ff, state_in;
   ctg_pkg::ctg_div_type    div_ff, div_in;
   ctg_pkg::ctg_horner_type hstep_ff, hstep_in;
   logic [IDX_W-1:0] next_idx_ff, next_idx_in, total_ff, total_in, idx_ff, idx_in;
   logic             running_ff, running_in;

   // Coefficients
   logic signed [COEFF_W-1:0] c0_ff, c0_in, c1_ff, c1_in, c2_ff, c2_in, c3_ff, c3_in;

   // Datapath
   logic [31:0]         t_ff, t_in;
   logic signed [63:0]  d_ff, d_in, s1_ff, s1_in, s2_ff, s2_in, x_ff, x_in;
   logic [DNUM_W-1:0]   num_ff, num_in;
   logic [31:0]         den_ff, den_in, rem_ff, rem_in;
   logic [63:0]         quo_ff, quo_in;
   logic                qsat_ff, qsat_in, dneg_ff, dneg_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [31:0]         tau_ff, tau_in;
   logic signed [63:0]  acc_ff, acc_in, prod_ff, prod_in;
   logic [63:0]         pl_ff, pl_in, ph_ff, ph_in;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_pos_ff, rsp_pos_in, rsp_vel_ff, rsp_vel_in;
   logic [15:0] rsp_num_ff, rsp_num_in;
   logic        rsp_last_ff, rsp_last_in, rsp_empty_ff, rsp_empty_in;

   // Shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   assign mul_p = mul_a * mul_b;

   logic [31:0] p_eff;
   assign p_eff = (per_ff == 32'd0) ? 32'd1 : per_ff;

   assign req_tready = (state_ff == ctg_pkg::ST_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_num_ff, rsp_vel_ff, rsp_pos_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_empty_ff;

   // Next state and datapath
   always_comb begin
      logic signed [32:0]  dif;
      logic signed [33:0]  sum2;
      logic signed [63:0]  src;
      logic [63:0]         mag;
      logic [32:0]         r2;
      logic                ge;
      logic [63:0]         qmag;
      logic signed [63:0]  dres;
      logic [32:0]         n33;
      logic [63:0]         amag;
      logic [95:0]         full;
      logic [95:0]         sh;
      logic [63:0]         pm;
      logic signed [63:0]  addend;
      logic [IDX_W:0]      idx_nx;

      state_in     = state_ff;
      div_in       = div_ff;
      hstep_in     = hstep_ff;
      next_idx_in  = next_idx_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      running_in   = running_ff;
      c0_in = c0_ff; c1_in = c1_ff; c2_in = c2_ff; c3_in = c3_ff;
      t_in = t_ff; d_in = d_ff; s1_in = s1_ff; s2_in = s2_ff; x_in = x_ff;
      num_in = num_ff; den_in = den_ff; rem_in = rem_ff; quo_in = quo_ff;
      qsat_in = qsat_ff; dneg_in = dneg_ff; cnt_in = cnt_ff;
      tau_in = tau_ff; acc_in = acc_ff; prod_in = prod_ff;
      pl_in = pl_ff; ph_in = ph_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pos_in = rsp_pos_ff; rsp_vel_in = rsp_vel_ff; rsp_num_in = rsp_num_ff;
      rsp_last_in = rsp_last_ff; rsp_empty_in = rsp_empty_ff;
      mul_a = 32'd0;
      mul_b = 32'd0;

      dif  = 33'(ep_ff) - 33'(sp_ff);
      sum2 = 34'(sv_ff) + 34'(sv_ff) + 34'(ev_ff);
      src  = x_ff;
      case (div_ff)
         ctg_pkg::DIV_QUAD_X:  src = d_ff + (d_ff <<< 1);
         ctg_pkg::DIV_CUBIC_X: src = -(d_ff <<< 1);
         default:              src = x_ff;
      endcase
      mag  = (src < 0) ? 64'(-src) : 64'(src);
      r2   = {rem_ff, num_ff[DNUM_W-1]};
      ge   = (r2 >= {1'b0, den_ff});
      qmag = (qsat_ff || (quo_ff > 64'(ctg_pkg::WIDE_LIM))) ? 64'(ctg_pkg::WIDE_LIM)
                                                             : quo_ff;
      dres = dneg_ff ? -$signed(qmag) : $signed(qmag);
      n33  = {1'b0, quo_ff[31:0]} + 33'(rem_ff != 32'd0);
      amag = (acc_ff < 0) ? 64'(-acc_ff) : 64'(acc_ff);
      full = {ph_ff, 32'd0} + {32'd0, pl_ff};
      sh   = full >> FRAC_BITS;
      pm   = (sh > 96'(ctg_pkg::WIDE_LIM)) ? 64'(ctg_pkg::WIDE_LIM) : sh[63:0];
      idx_nx = {1'b0, idx_ff} + (IDX_W+1)'(1);
      case (hstep_ff)
         ctg_pkg::H_POS_QUAD:  addend = 64'(c2_ff);
         ctg_pkg::H_POS_CONST: addend = 64'(c0_ff);
         ctg_pkg::H_VEL_QUAD:  addend = 64'(c2_ff) <<< 1;
         default:              addend = 64'(c1_ff);
      endcase

      // Retire a taken result
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      case (state_ff)
         ctg_pkg::ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               if (req_tdata[0]) begin
                  running_in  = 1'b0;
                  next_idx_in = '0;
                  total_in    = '0;
                  state_in    = ctg_pkg::ST_START;
               end else if (running_ff) begin
                  idx_in   = next_idx_ff;
                  state_in = ctg_pkg::ST_TAU;
               end
            end
         end
         ctg_pkg::ST_START: begin
            if (et_ff <= st_ff) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = 32'd0;
               rsp_vel_in   = 32'd0;
               rsp_num_in   = 16'd0;
               rsp_last_in  = 1'b1;
               rsp_empty_in = 1'b1;
               state_in     = ctg_pkg::ST_IDLE;
            end else begin
               t_in   = et_ff - st_ff;
               d_in   = 64'(dif) <<< FRAC_BITS;
               s1_in  = 64'(33'(sv_ff) + 33'(ev_ff)) <<< FRAC_BITS;
               s2_in  = 64'(sum2) <<< FRAC_BITS;
               c0_in  = COEFF_W'(sp_ff) <<< FRAC_BITS;
               c1_in  = COEFF_W'(sv_ff) <<< FRAC_BITS;
               div_in = ctg_pkg::DIV_QUAD_X;
               state_in = ctg_pkg::ST_DIV_LOAD;
            end
         end
         ctg_pkg::ST_DIV_LOAD: begin
            rem_in  = 32'd0;
            quo_in  = 64'd0;
            qsat_in = 1'b0;
            cnt_in  = CNT_W'(DNUM_W - 1);
            if (div_ff == ctg_pkg::DIV_COUNT) begin
               num_in  = DNUM_W'(t_ff);
               den_in  = p_eff;
               dneg_in = 1'b0;
            end else begin
               num_in  = DNUM_W'(mag[62:0]) << FRAC_BITS;
               den_in  = t_ff;
               dneg_in = (src < 0);
            end
            state_in = ctg_pkg::ST_DIV_RUN;
         end
         ctg_pkg::ST_DIV_RUN: begin
            // One quotient bit per cycle
            rem_in  = ge ? 32'(r2 - {1'b0, den_ff}) : r2[31:0];
            quo_in  = {quo_ff[62:0], ge};
            qsat_in = qsat_ff | quo_ff[63] | quo_ff[62];
            num_in  = num_ff << 1;
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) state_in = ctg_pkg::ST_DIV_POST;
         end
         ctg_pkg::ST_DIV_POST: begin
            state_in = ctg_pkg::ST_DIV_LOAD;
            case (div_ff)
               ctg_pkg::DIV_QUAD_X: begin
                  x_in   = sat_to(65'(dres) - 65'(s2_ff), ctg_pkg::WIDE_LIM);
                  div_in = ctg_pkg::DIV_QUAD;
               end
               ctg_pkg::DIV_QUAD: begin
                  c2_in  = COEFF_W'(sat_to(65'(dres), COEFF_LIM));
                  div_in = ctg_pkg::DIV_CUBIC_X;
               end
               ctg_pkg::DIV_CUBIC_X: begin
                  x_in   = sat_to(65'(dres) + 65'(s1_ff), ctg_pkg::WIDE_LIM);
                  div_in = ctg_pkg::DIV_CUBIC_Y;
               end
               ctg_pkg::DIV_CUBIC_Y: begin
                  x_in   = dres;
                  div_in = ctg_pkg::DIV_CUBIC;
               end
               ctg_pkg::DIV_CUBIC: begin
                  c3_in  = COEFF_W'(sat_to(65'(dres), COEFF_LIM));
                  div_in = ctg_pkg::DIV_COUNT;
               end
               default: begin
                  // Sample count, rounded up and capped
                  total_in   = (n33 > 33'(MAX_SAMPLES)) ? IDX_W'(MAX_SAMPLES)
                                                        : IDX_W'(n33);
                  running_in = 1'b1;
                  idx_in     = '0;
                  state_in   = ctg_pkg::ST_TAU;
               end
            endcase
         end
         ctg_pkg::ST_TAU: begin
            mul_a    = 32'(idx_ff);
            mul_b    = p_eff;
            tau_in   = (mul_p[63:32] != 32'd0) ? 32'hFFFF_FFFF : mul_p[31:0];
            acc_in   = 64'(c3_ff);
            hstep_in = ctg_pkg::H_POS_QUAD;
            state_in = ctg_pkg::ST_MUL_LO;
         end
         ctg_pkg::ST_MUL_LO: begin
            mul_a    = amag[31:0];
            mul_b    = tau_ff;
            pl_in    = mul_p;
            state_in = ctg_pkg::ST_MUL_HI;
         end
         ctg_pkg::ST_MUL_HI: begin
            mul_a    = {1'b0, amag[62:32]};
            mul_b    = tau_ff;
            ph_in    = mul_p;
            state_in = ctg_pkg::ST_MUL_FIN;
         end
         ctg_pkg::ST_MUL_FIN: begin
            prod_in  = (acc_ff < 0) ? -$signed(pm) : $signed(pm);
            state_in = ctg_pkg::ST_ACC;
         end
         ctg_pkg::ST_ACC: begin
            acc_in   = sat_to(65'(addend) + 65'(prod_ff), ctg_pkg::WIDE_LIM);
            state_in = ctg_pkg::ST_NEXT;
         end
         ctg_pkg::ST_NEXT: begin
            state_in = ctg_pkg::ST_MUL_LO;
            case (hstep_ff)
               ctg_pkg::H_POS_QUAD: hstep_in = ctg_pkg::H_POS_LIN;
               ctg_pkg::H_POS_LIN:  hstep_in = ctg_pkg::H_POS_CONST;
               ctg_pkg::H_POS_CONST: begin
                  rsp_pos_in = to_out(acc_ff);
                  acc_in     = 64'(c3_ff) + (64'(c3_ff) <<< 1);
                  hstep_in   = ctg_pkg::H_VEL_QUAD;
               end
               ctg_pkg::H_VEL_QUAD: hstep_in = ctg_pkg::H_VEL_LIN;
               default: begin
                  // Deliver the sample, advance the index
                  rsp_vel_in   = to_out(acc_ff);
                  rsp_num_in   = 16'(idx_ff);
                  rsp_last_in  = (idx_nx >= {1'b0, total_ff});
                  rsp_empty_in = 1'b0;
                  rsp_valid_in = 1'b1;
                  next_idx_in  = IDX_W'(idx_nx);
                  if (idx_nx >= {1'b0, total_ff}) running_in = 1'b0;
                  state_in     = ctg_pkg::ST_IDLE;
               end
            endcase
         end
         default: state_in = ctg_pkg::ST_IDLE;
      endcase
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff  <= '0;
         ep_ff  <= '0;
         sv_ff  <= '0;
         ev_ff  <= '0;
         st_ff  <= '0;
         et_ff  <= 32'd65536;
         per_ff <= 32'd66;
      end else if (csr_we) begin
         case (csr_index)
            ctg_pkg::REG_START_POS: sp_ff  <= $signed(csr_wdata);
            ctg_pkg::REG_END_POS:   ep_ff  <= $signed(csr_wdata);
            ctg_pkg::REG_START_VEL: sv_ff  <= $signed(csr_wdata);
            ctg_pkg::REG_END_VEL:   ev_ff  <= $signed(csr_wdata);
            ctg_pkg::REG_START_TIM: st_ff  <= csr_wdata;
            ctg_pkg::REG_END_TIM:   et_ff  <= csr_wdata;
            ctg_pkg::REG_PERIOD:    per_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ctg_pkg::ST_IDLE;
         div_ff       <= ctg_pkg::DIV_QUAD_X;
         hstep_ff     <= ctg_pkg::H_POS_QUAD;
         next_idx_ff  <= '0;
         total_ff     <= '0;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         c0_ff        <= '0;
         c1_ff        <= '0;
         c2_ff        <= '0;
         c3_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         div_ff       <= div_in;
         hstep_ff     <= hstep_in;
         next_idx_ff  <= next_idx_in;
         total_ff     <= total_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
         c0_ff        <= c0_in;
         c1_ff        <= c1_in;
         c2_ff        <= c2_in;
         c3_ff        <= c3_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      t_ff         <= t_in;
      d_ff         <= d_in;
      s1_ff        <= s1_in;
      s2_ff        <= s2_in;
      x_ff         <= x_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      qsat_ff      <= qsat_in;
      dneg_ff      <= dneg_in;
      cnt_ff       <= cnt_in;
      tau_ff       <= tau_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      pl_ff        <= pl_in;
      ph_ff        <= ph_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_vel_ff   <= rsp_vel_in;
      rsp_num_ff   <= rsp_num_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   // Checks
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> rsp_last_ff)
      else $error("empty span result not flagged last");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (next_idx_ff < total_ff))
      else $error("running with index past sample count");

   a_count_capped: assert property (@(posedge clock) disable iff (reset)
      total_ff <= IDX_W'(MAX_SAMPLES))
      else $error("sample count above cap");

   a_div_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ctg_pkg::ST_DIV_RUN) |->
         ($past(state_ff) == ctg_pkg::ST_DIV_LOAD || $past(state_ff) == ctg_pkg::ST_DIV_RUN))
      else $error("divider run without load");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> rsp_valid_ff && $stable(rsp_pos_ff))
      else $error("waiting result overwritten");

endmodule

// ----- sim/cubic_trajectory_generator_test.sv -----
module cubic_trajectory_generator_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB = ctg_pkg::FRAC_BITS_DEF;
   localparam int MAXN = ctg_pkg::MAX_SAMPLES_DEF;
   localparam logic signed [63:0] LIM = ctg_pkg::WIDE_LIM;
   localparam logic signed [63:0] CLIM = (64'sd1 <<< (31 + FB)) - 64'sd1;
   localparam longint CYCLE_LIMIT = 64'd12_000_000;

   typedef struct packed {
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic [15:0]        sample_number;
      logic               last_sample;
      logic               empty_span;
   } sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [ctg_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [ctg_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ctg_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [ctg_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic rsp_tuser;

   cubic_trajectory_generator dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: registers and trajectory
   logic [31:0] r_spos, r_epos, r_svel, r_evel, r_stim, r_etim, r_per;
   logic signed [63:0] k0, k1, k2, k3;
   int unsigned idx_next, total;
   bit active;

   sample_type expected_samples[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit recv_hold = 0;
   longint cycles = 0;

   function automatic logic signed [63:0] clamp(logic signed [63:0] x,
                                                logic signed [63:0] l);
      if (x > l) return l;
      if (x < -l) return -l;
      return x;
   endfunction

   function automatic logic [63:0] mag(logic signed [63:0] x);
      return x < 0 ? 64'd0 - 64'(x) : 64'(x);
   endfunction

   function automatic logic signed [63:0] signed_sat(bit neg, logic [63:0] m);
      if (m > 64'(LIM)) m = 64'(LIM);
      return neg ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [63:0] div_span(logic signed [63:0] x,
                                                   logic [63:0] t);
      logic [63:0] m, hi, rm, r;
      m = mag(x);
      hi = m / t;
      rm = m % t;
      if (hi > (64'(LIM) >> FB)) r = 64'(LIM);
      else r = (hi << FB) + ((rm << FB) / t);
      return signed_sat(x < 0, r);
   endfunction

   function automatic logic signed [63:0] mul_tau(logic signed [63:0] x,
                                                  logic [63:0] tau);
      logic [63:0] m, ph, pl, r;
      m = mag(clamp(x, LIM));
      ph = (m >> 32) * tau;
      pl = (m & 64'hFFFF_FFFF) * tau;
      if (ph > (64'(LIM) >> (32 - FB))) r = 64'(LIM);
      else r = (ph << (32 - FB)) + (pl >> FB);
      return signed_sat(x < 0, r);
   endfunction

   function automatic logic [31:0] narrow(logic signed [63:0] acc);
      logic signed [63:0] v;
      v = signed_sat(acc < 0, mag(acc) >> FB);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   function automatic sample_type eval_sample(int unsigned i);
      sample_type s;
      logic [63:0] tau;
      logic signed [63:0] acc;
      tau = 64'(i) * ((r_per != 0) ? 64'(r_per) : 64'd1);
      if (tau > 64'hFFFF_FFFF) tau = 64'hFFFF_FFFF;
      acc = k3;
      acc = clamp(k2 + mul_tau(acc, tau), LIM);
      acc = clamp(k1 + mul_tau(acc, tau), LIM);
      acc = clamp(k0 + mul_tau(acc, tau), LIM);
      s.position = narrow(acc);
      acc = 3 * k3;
      acc = clamp(2 * k2 + mul_tau(acc, tau), LIM);
      acc = clamp(k1 + mul_tau(acc, tau), LIM);
      s.velocity = narrow(acc);
      s.sample_number = i[15:0];
      s.last_sample = (i + 1 >= total);
      s.empty_span = 1'b0;
      return s;
   endfunction

   // Advance the trajectory model by one tick
   task automatic predict_tick(bit restart);
      logic [63:0] t, p, n;
      logic signed [63:0] d, s1, s2, x, v0, vf;
      sample_type s;
      if (restart) begin
         idx_next = 0;
         total = 0;
         active = 0;
         if (r_etim <= r_stim) begin
            s = '0;
            s.last_sample = 1'b1;
            s.empty_span = 1'b1;
            expected_samples.push_back(s);
            return;
         end
         t = 64'(r_etim) - 64'(r_stim);
         v0 = 64'($signed(r_svel));
         vf = 64'($signed(r_evel));
         d = (64'($signed(r_epos)) - 64'($signed(r_spos))) <<< FB;
         s1 = (v0 + vf) <<< FB;
         s2 = (2 * v0 + vf) <<< FB;
         k0 = 64'($signed(r_spos)) <<< FB;
         k1 = v0 <<< FB;
         x = clamp(div_span(3 * d, t) - s2, LIM);
         k2 = clamp(div_span(x, t), CLIM);
         x = clamp(div_span(-2 * d, t) + s1, LIM);
         k3 = clamp(div_span(div_span(x, t), t), CLIM);
         p = (r_per != 0) ? 64'(r_per) : 64'd1;
         n = t / p + 64'((t % p) != 0);
         if (n > 64'(MAXN)) n = 64'(MAXN);
         total = 32'(n);
         active = 1;
      end else if (!active) begin
         return;
      end
      expected_samples.push_back(eval_sample(idx_next));
      idx_next++;
      if (idx_next >= total) active = 0;
   endtask

   // Write one register, only while idle; the caller drops the enable
   task automatic write_reg(logic [ctg_pkg::CSR_IDX_W-1:0] i, logic [31:0] v);
      csr_we <= 1'b1;
      csr_index <= i;
      csr_wdata <= v;
      @(posedge clock);
      case (i)
         ctg_pkg::REG_START_POS: r_spos = v;
         ctg_pkg::REG_END_POS:   r_epos = v;
         ctg_pkg::REG_START_VEL: r_svel = v;
         ctg_pkg::REG_END_VEL:   r_evel = v;
         ctg_pkg::REG_START_TIM: r_stim = v;
         ctg_pkg::REG_END_TIM:   r_etim = v;
         ctg_pkg::REG_PERIOD:    r_per = v;
         default: ;
      endcase
   endtask

   // Offer one tick and hold it until the transfer
   task automatic send_tick(bit restart);
      do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      req_tvalid <= 1'b1;
      req_tdata <= {7'($urandom), restart};
      do @(posedge clock); while (!req_tready);
      predict_tick(restart);
      req_tvalid <= 1'b0;
   endtask

   // Let the block settle, then it is safe to reconfigure
   task automatic drain;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic set_path(logic [31:0] sp, logic [31:0] ep, logic [31:0] sv,
                           logic [31:0] ev, logic [31:0] st, logic [31:0] et,
                           logic [31:0] per);
      drain();
      write_reg(ctg_pkg::REG_START_POS, sp);
      write_reg(ctg_pkg::REG_END_POS, ep);
      write_reg(ctg_pkg::REG_START_VEL, sv);
      write_reg(ctg_pkg::REG_END_VEL, ev);
      write_reg(ctg_pkg::REG_START_TIM, st);
      write_reg(ctg_pkg::REG_END_TIM, et);
      write_reg(ctg_pkg::REG_PERIOD, per);
      csr_we <= 1'b0;
   endtask

   task automatic run_path(int ticks);
      send_tick(1'b1);
      repeat (ticks) send_tick(1'b0);
   endtask

   // Extremes of every register, empty span, idle ticks, zero period
   task automatic test_directed;
      send_tick(1'b0);
      run_path(3);
      set_path(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h0, 32'h0000_0003, 32'h0);
      run_path(4);
      set_path(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_path(2);
      set_path(32'h0001_0000, 32'h0005_0000, 32'h0, 32'h0,
               32'h0002_0000, 32'h0002_0000, 32'h1);
      run_path(1);
      set_path(32'h0, 32'h0000_1000, 32'hFFFF_0000, 32'h0001_0000,
               32'hFFFF_FFFF, 32'h0, 32'h4000);
      run_path(2);
      // period so large that one sample covers the span
      set_path(32'h0003_0000, 32'hFFFD_0000, 32'h0, 32'h0,
               32'h1, 32'h0001_0000, 32'h8000_0000);
      run_path(3);
   endtask

   // Back-pressure: long receiver hold while ticks keep coming
   task automatic test_backpressure;
      set_path(32'h0, 32'h000A_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000,
               32'h2000);
      recv_hold = 1;
      run_path(9);
      drain();
   endtask

   function automatic logic [31:0] rand_word;
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2_000_000)) - 1_000_000);
         2: return {$urandom_range(1) ? 16'hFFFF : 16'h0, 16'($urandom)};
         default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
   endfunction

   // Random paths: mostly well-formed runs, some noise and early restarts
   task automatic test_random(int items);
      int sent;
      int len;
      logic [31:0] st, per;
      sent = 0;
      while (sent < items) begin
         st = ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'h40000);
         per = ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'h8000);
         set_path(rand_word(), rand_word(), rand_word(), rand_word(), st,
                  ($urandom_range(9) == 0) ? $urandom_range(st) :
                  st + $urandom_range(32'h20000),
                  per);
         len = $urandom_range(20);
         if ($urandom_range(3) == 0) send_tick(1'b0);
         run_path(len);
         sent += len + 1;
      end
   endtask

   // Receiver ready, with random idling and a long hold
   initial begin
      int hold;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (recv_hold) begin
            rsp_tready <= 1'b0;
            hold = 0;
            while (hold < 2000) begin
               @(posedge clock);
               hold++;
            end
            recv_hold = 0;
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Check each transfer against the oldest expected sample
   always @(posedge clock) begin
      sample_type got, exp_s;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[79:64], rsp_tlast,
                rsp_tuser};
         if (expected_samples.size() == 0) begin
            $error("unexpected sample %h", got);
            errors++;
         end else begin
            exp_s = expected_samples.pop_front();
            if (got.position !== exp_s.position) begin
               $error("position exp %h got %h", exp_s.position, got.position);
               errors++;
            end
            if (got.velocity !== exp_s.velocity) begin
               $error("velocity exp %h got %h", exp_s.velocity, got.velocity);
               errors++;
            end
            if (got.sample_number !== exp_s.sample_number) begin
               $error("sample_number exp %0d got %0d", exp_s.sample_number,
                      got.sample_number);
               errors++;
            end
            if (got.last_sample !== exp_s.last_sample) begin
               $error("last_sample exp %b got %b", exp_s.last_sample,
                      got.last_sample);
               errors++;
            end
            if (got.empty_span !== exp_s.empty_span) begin
               $error("empty_span exp %b got %b", exp_s.empty_span,
                      got.empty_span);
               errors++;
            end
         end
      end
   end

   // Timeout
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      r_spos = 0; r_epos = 0; r_svel = 0; r_evel = 0;
      r_stim = 0; r_etim = 32'h0001_0000; r_per = 66;
      k0 = 0; k1 = 0; k2 = 0; k3 = 0;
      idx_next = 0; total = 0; active = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      send_idle_pct = 31; recv_idle_pct = 62;
      test_random(200);
      send_idle_pct = 62; recv_idle_pct = 31;
      test_random(200);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(200);
      drain();
      if (errors == 0 && expected_samples.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
src/ctg_pkg.sv
src/cubic_trajectory_generator.sv
sim/cubic_trajectory_generator_test.sv
